// File: src/p256a_pkg.sv
// Package for the P-256 order modular ALU: payload types, curve constants,
// controller command and status structs. No dependencies.
`default_nettype none
package p256a_pkg;

  localparam int LimbBits = 32;
  localparam int Words    = 256 / LimbBits;
  localparam int WordIdxBits = $clog2(Words);

  typedef logic [1:0] command_code_t;
  localparam command_code_t CmdAdd    = 2'd0;
  localparam command_code_t CmdMul    = 2'd1;
  localparam command_code_t CmdInv    = 2'd2;
  localparam command_code_t CmdReduce = 2'd3;

  typedef struct packed {
    command_code_t command;
    logic [63:0] a_word0;
    logic [63:0] a_word1;
    logic [63:0] a_word2;
    logic [63:0] a_word3;
    logic [63:0] b_word0;
    logic [63:0] b_word1;
    logic [63:0] b_word2;
    logic [63:0] b_word3;
  } request_t;

  typedef struct packed {
    logic [63:0] result_word0;
    logic [63:0] result_word1;
    logic [63:0] result_word2;
    logic [63:0] result_word3;
  } result_t;

  localparam logic [255:0] OrderN =
    256'hffffffff00000000ffffffffffffffffbce6faada7179e84f3b9cac2fc632551;
  localparam logic [255:0] RSquared =
    256'h66e12d94f3d956202845b2392b6bec594699799c49bd6fa683244c95be79eea2;
  localparam logic [255:0] ExpNMinus2 =
    256'hffffffff00000000ffffffffffffffffbce6faada7179e84f3b9cac2fc63254f;
  localparam logic [255:0] MontOne =
    256'h00000000ffffffff00000000000000004319055258e8617b0c46353d039cdaaf;
  localparam logic [LimbBits-1:0] NegNInv = 32'hee00bc4f;

  // Operand selections for the Montgomery product.
  typedef enum logic [2:0] {
    SelInA, SelAcc, SelRSq, SelBase, SelOne, SelInB
  } operand_sel_t;

  // Where a finished product is written.
  typedef enum logic [1:0] {
    DstAcc, DstBase
  } product_dst_t;

  typedef enum logic [3:0] {
    StIdle, StLoad, StAddSub, StMul1, StMul2, StInvBase, StInvSquare,
    StInvMult, StInvExit, StWait, StDone
  } ctrl_state_t;

  typedef struct packed {
    logic         load;
    logic         start_mont;
    operand_sel_t x_sel;
    operand_sel_t y_sel;
    product_dst_t dst;
    logic         start_addsub;
    logic         set_acc_one;
    logic         push_result;
  } dp_cmd_t;

  typedef struct packed {
    logic         mont_done;
    logic         addsub_done;
    logic         exp_bit;
    command_code_t command;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/p256a_datapath.sv
// Datapath: operand registers, one shared limb multiplier running CIOS
// Montgomery products word by word, and the add/reduce unit. Uses p256a_pkg.
`default_nettype none
module p256a_datapath import p256a_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire request_t   req,
  input  wire dp_cmd_t    cmd,
  input  wire logic [7:0] exp_idx,
  output dp_status_t      status,
  output logic [255:0]    result
);

  logic [255:0] a, b, acc, base;
  logic [255:0] work_res;
  logic [1:0] command;
  logic [LimbBits-1:0] x_w [Words];
  logic [LimbBits-1:0] y_w [Words];
  logic [LimbBits-1:0] n_w [Words];
  logic [LimbBits-1:0] t [Words+2];
  logic [255:0] xs, ys;
  product_dst_t dst;
  logic busy;
  logic [1:0] phase; // 0 multiply pass, 1 reduce pass, 2 final subtract
  logic [WordIdxBits-1:0] i, j;
  logic [WordIdxBits:0] tj, tj_prev;
  logic [LimbBits-1:0] q;
  logic [LimbBits-1:0] carry;
  logic mont_done, addsub_done;

  always_comb begin
    for (int k = 0; k < Words; k++) begin
      x_w[k] = xs[k*LimbBits +: LimbBits];
      y_w[k] = ys[k*LimbBits +: LimbBits];
      n_w[k] = OrderN[k*LimbBits +: LimbBits];
    end
  end

  // Accumulator indexes for the current and the previous word.
  assign tj      = {1'b0, j};
  assign tj_prev = {1'b0, j - 1'b1};

  function automatic logic [255:0] pick(operand_sel_t s, logic [255:0] pa, logic [255:0] pb,
                                        logic [255:0] pacc, logic [255:0] pbase);
    case (s)
      SelInA:  pick = pa;
      SelInB:  pick = pb;
      SelAcc:  pick = pacc;
      SelRSq:  pick = RSquared;
      SelBase: pick = pbase;
      SelOne:  pick = 256'd1;
      default: pick = pa;
    endcase
  endfunction

  // One limb multiply-accumulate per cycle.
  logic [LimbBits-1:0] mul_a, mul_b, add_t;
  logic [2*LimbBits-1:0] mac;
  always_comb begin
    mul_a = x_w[i];
    mul_b = y_w[j];
    add_t = t[tj];
    if (phase == 2'd1) begin
      mul_a = q;
      mul_b = n_w[j];
    end
    mac = mul_a * mul_b + {{LimbBits{1'b0}}, add_t} + {{LimbBits{1'b0}}, carry};
  end

  // Final conditional subtraction of n from high:t.
  logic [255:0] t_low;
  logic [256:0] t_diff;
  always_comb begin
    for (int k = 0; k < Words; k++) t_low[k*LimbBits +: LimbBits] = t[k];
    t_diff = {1'b0, t_low} - {1'b0, OrderN};
  end

  // Add and reduce path.
  logic [256:0] sum, as_diff, as_in;
  logic [255:0] as_res;
  always_comb begin
    as_in   = (command == CmdAdd) ? ({1'b0, a} + {1'b0, b}) : {1'b0, a};
    sum     = as_in;
    as_diff = {1'b0, sum[255:0]} - {1'b0, OrderN};
    as_res  = (!sum[256] && as_diff[256]) ? sum[255:0] : as_diff[255:0];
  end

  // Product sequencing, operand registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      mont_done   <= 1'b0;
      addsub_done <= 1'b0;
    end else begin
      addsub_done <= cmd.start_addsub;
      mont_done   <= busy && !cmd.start_mont && (phase == 2'd2);
      if (cmd.load) begin
        command <= req.command;
        a <= {req.a_word3, req.a_word2, req.a_word1, req.a_word0};
        b <= {req.b_word3, req.b_word2, req.b_word1, req.b_word0};
      end
      if (cmd.set_acc_one) acc <= MontOne;
      if (cmd.start_addsub) work_res <= as_res;
      if (cmd.push_result) result <= work_res;
      if (cmd.start_mont) begin
        xs    <= pick(cmd.x_sel, a, b, acc, base);
        ys    <= pick(cmd.y_sel, a, b, acc, base);
        dst   <= cmd.dst;
        busy  <= 1'b1;
        phase <= 2'd0;
        i     <= '0;
        j     <= '0;
        carry <= '0;
        for (int k = 0; k < Words + 2; k++) t[k] <= '0;
      end else if (busy) begin
        case (phase)
          2'd0: begin
            t[tj] <= mac[LimbBits-1:0];
            if (j == WordIdxBits'(Words - 1)) begin
              {t[Words+1], t[Words]} <= {{LimbBits{1'b0}}, t[Words]}
                + {{LimbBits{1'b0}}, mac[2*LimbBits-1:LimbBits]};
              q     <= LimbBits'(t[0] * NegNInv);
              phase <= 2'd1;
              j     <= '0;
              carry <= '0;
            end else begin
              carry <= mac[2*LimbBits-1:LimbBits];
              j     <= j + 1'b1;
            end
          end
          2'd1: begin
            if (j != '0) t[tj_prev] <= mac[LimbBits-1:0];
            if (j == WordIdxBits'(Words - 1)) begin
              logic [2*LimbBits-1:0] v;
              v = {{LimbBits{1'b0}}, t[Words]} + {{LimbBits{1'b0}}, mac[2*LimbBits-1:LimbBits]};
              t[Words-1] <= v[LimbBits-1:0];
              t[Words]   <= t[Words+1] + v[2*LimbBits-1:LimbBits];
              t[Words+1] <= '0;
              carry      <= '0;
              j          <= '0;
              if (i == WordIdxBits'(Words - 1)) phase <= 2'd2;
              else begin
                phase <= 2'd0;
                i     <= i + 1'b1;
              end
            end else begin
              carry <= mac[2*LimbBits-1:LimbBits];
              j     <= j + 1'b1;
            end
          end
          default: begin
            logic [255:0] r;
            r = (t[Words] == '0 && t_diff[256]) ? t_low : t_diff[255:0];
            if (dst == DstBase) base <= r;
            else acc <= r;
            work_res <= r;
            busy     <= 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    status.mont_done   = mont_done;
    status.addsub_done = addsub_done;
    status.exp_bit     = ExpNMinus2[exp_idx];
    status.command     = command;
  end

endmodule
`default_nettype wire

// File: src/p256a_controller.sv
// Controller state machine: sequences products for multiply and inverse
// and hands results to the output register. Uses p256a_pkg.
`default_nettype none
module p256a_controller import p256a_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic [7:0]      exp_idx
);

  ctrl_state_t state, state_next;
  logic [7:0] bit_idx;
  logic started;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      StIdle: if (in_valid) state_next = StLoad;
      StLoad: begin
        case (status.command)
          CmdMul:  state_next = StMul1;
          CmdInv:  state_next = StInvBase;
          default: state_next = StAddSub;
        endcase
      end
      StAddSub:    state_next = StWait;
      StWait:      if (status.addsub_done) state_next = StDone;
      StMul1:      if (started && status.mont_done) state_next = StMul2;
      StMul2:      if (started && status.mont_done) state_next = StDone;
      StInvBase:   if (started && status.mont_done) state_next = StInvSquare;
      StInvSquare: if (started && status.mont_done)
                     state_next = status.exp_bit ? StInvMult
                                : (bit_idx == 8'd0 ? StInvExit : StInvSquare);
      StInvMult:   if (started && status.mont_done)
                     state_next = (bit_idx == 8'd0) ? StInvExit : StInvSquare;
      StInvExit:   if (started && status.mont_done) state_next = StDone;
      StDone:      if (!out_valid || !out_stall) state_next = StIdle;
      default:     state_next = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    cmd.load = (state == StIdle) && in_valid;
    cmd.start_addsub = (state == StAddSub);
    cmd.set_acc_one = (state == StInvBase) && !started;
    cmd.start_mont = !started && (state == StMul1 || state == StMul2 ||
      state == StInvBase || state == StInvSquare || state == StInvMult || state == StInvExit);
    cmd.push_result = (state == StDone) && (!out_valid || !out_stall);
    cmd.x_sel = SelAcc;
    cmd.y_sel = SelAcc;
    cmd.dst   = DstAcc;
    case (state)
      StMul1:    begin cmd.x_sel = SelInA; cmd.y_sel = SelInB; end
      StMul2:    begin cmd.x_sel = SelAcc; cmd.y_sel = SelRSq; end
      StInvBase: begin cmd.x_sel = SelInA; cmd.y_sel = SelRSq; cmd.dst = DstBase; end
      StInvMult: begin cmd.x_sel = SelAcc; cmd.y_sel = SelBase; end
      StInvExit: begin cmd.x_sel = SelAcc; cmd.y_sel = SelOne; end
      default:   begin cmd.x_sel = SelAcc; cmd.y_sel = SelAcc; end
    endcase
    in_stall  = (state != StIdle);
    exp_idx   = bit_idx;
  end

  // State, product start flag, exponent bit counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      started   <= 1'b0;
      bit_idx   <= 8'd255;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // A finished product re-arms the start, also when the state repeats.
      if (state_next != state || status.mont_done) started <= 1'b0;
      else if (cmd.start_mont) started <= 1'b1;
      if (state == StLoad) bit_idx <= 8'd255;
      else if (started && status.mont_done &&
               ((state == StInvSquare && !status.exp_bit) || state == StInvMult))
        bit_idx <= bit_idx - 8'd1;
      if (cmd.push_result) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: src/p256_order_modular_alu_unit.sv
// Modular ALU over the P-256 group order: add, multiply, inverse, reduce.
// Each Montgomery product runs on one shared 32x32 limb multiplier and holds the
// controller until it finishes; multiply is two products, inverse is 258+popcount(n-2)
// products. A new request is taken once the previous one moves to the output
// register. rst (synchronous) idles the controller, empties output.
`default_nettype none
module p256_order_modular_alu_unit import p256a_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire request_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output result_t       out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [7:0] exp_idx;
  logic [255:0] result;

  p256a_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .status, .cmd, .exp_idx
  );

  p256a_datapath u_dp (
    .clk, .rst, .req(in_data), .cmd, .exp_idx, .status, .result
  );

  assign out_data = {result[63:0], result[127:64], result[191:128], result[255:192]};

  // A request is loaded only at an accepting edge.
  assert property (@(posedge clk) disable iff (rst) cmd.load |-> in_valid && !in_stall)
    else $error("request loaded without handshake");
  // A held result does not change under stall.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // Product and add completions never coincide.
  assert property (@(posedge clk) disable iff (rst)
    !(status.mont_done && status.addsub_done))
    else $error("two completions at once");

endmodule
`default_nettype wire

// File: tb/sv/p256_alu_checker.sv
`timescale 1ns / 100ps
// Result checker for the P-256 order modular ALU: watches both channels,
// predicts each result and compares it. Depends on p256a_pkg.
module p256_alu_checker import p256a_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  request_t in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  result_t  out_data,
  output int       fail_count,
  output int       pending
);

  result_t      expected_results[$];
  logic [255:0] n_neg_inv;

  // Compute -n^-1 mod 2^256 by Newton iteration; n*n is 1 mod 8 for odd n.
  initial begin
    logic [255:0] inv;
    fail_count = 0;
    inv = OrderN;
    repeat (8) inv = inv * (256'd2 - OrderN * inv);
    n_neg_inv = -inv;
  end

  // Montgomery product x*y/2^256 with one final conditional subtraction of n.
  function automatic logic [255:0] redc_mul(input logic [255:0] x, input logic [255:0] y);
    logic [511:0] xy;
    logic [255:0] m;
    logic [512:0] sum;
    logic [256:0] t;
    xy  = {256'd0, x} * {256'd0, y};
    m   = xy[255:0] * n_neg_inv;
    sum = {1'b0, xy} + {257'd0, m} * {257'd0, OrderN};
    t   = sum[512:256];
    return (t >= {1'b0, OrderN}) ? 256'(t - {1'b0, OrderN}) : t[255:0];
  endfunction

  function automatic result_t alu_predict(input request_t r);
    logic [255:0] a, b, base, acc, res;
    logic [256:0] sum;
    result_t o;
    a = {r.a_word3, r.a_word2, r.a_word1, r.a_word0};
    b = {r.b_word3, r.b_word2, r.b_word1, r.b_word0};
    case (r.command)
      CmdAdd: begin
        sum = {1'b0, a} + {1'b0, b};
        res = (sum >= {1'b0, OrderN}) ? 256'(sum - {1'b0, OrderN}) : sum[255:0];
      end
      CmdMul: begin
        res = redc_mul(redc_mul(a, b), RSquared);
      end
      CmdInv: begin
        // Fermat power to n-2, square and multiply in the Montgomery domain.
        base = redc_mul(a, RSquared);
        acc  = MontOne;
        for (int i = 255; i >= 0; i--) begin
          acc = redc_mul(acc, acc);
          if (ExpNMinus2[i]) acc = redc_mul(acc, base);
        end
        res = redc_mul(acc, 256'd1);
      end
      default: begin
        res = (a >= OrderN) ? a - OrderN : a;
      end
    endcase
    o.result_word0 = res[63:0];
    o.result_word1 = res[127:64];
    o.result_word2 = res[191:128];
    o.result_word3 = res[255:192];
    return o;
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    fail_count++;
  endtask

  assign pending = expected_results.size();

  // Predict on each accepted request; compare each accepted result.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) expected_results.push_back(alu_predict(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result with no request outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_word0 !== want.result_word0)
            report("result_word0", out_data.result_word0, want.result_word0);
          if (out_data.result_word1 !== want.result_word1)
            report("result_word1", out_data.result_word1, want.result_word1);
          if (out_data.result_word2 !== want.result_word2)
            report("result_word2", out_data.result_word2, want.result_word2);
          if (out_data.result_word3 !== want.result_word3)
            report("result_word3", out_data.result_word3, want.result_word3);
        end
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the P-256 order modular ALU testbench: clock, reset, request and
// result stimulus, watchdog and verdict. Depends on p256a_pkg and the checker.
module tb_top;
  import p256a_pkg::*;

  localparam int NumRandom = 1930;
  localparam int IdleLimit = 250000;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  request_t in_data;
  logic     out_valid;
  logic     out_stall;
  result_t  out_data;
  int       fail_count;
  int       pending;
  int       idle_cycles;
  int       results_seen;
  bit       no_idle;

  p256_order_modular_alu_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  p256_alu_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if nothing is accepted for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [255:0] random_operand();
    logic [255:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return OrderN + 256'($urandom_range(0, 3)) - 256'($urandom_range(0, 3));
      1: return '1 - 256'($urandom_range(0, 7));
      2: return 256'($urandom_range(0, 5));
      3: return OrderN + (v >> $urandom_range(200, 255));
      default: return v;
    endcase
  endfunction

  function automatic request_t make_request(input command_code_t cmd, input logic [255:0] a,
                                            input logic [255:0] b);
    request_t r;
    r.command = cmd;
    {r.a_word3, r.a_word2, r.a_word1, r.a_word0} = a;
    {r.b_word3, r.b_word2, r.b_word1, r.b_word0} = b;
    return r;
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  task automatic send(input request_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    #1;
    while (in_stall) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: random stalls, one long hold-off early in the random part.
  initial begin
    int gap;
    bit held;
    out_stall = 1'b1;
    results_seen = 0;
    held = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (!held && results_seen == 40) begin
        gap = 3000;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      #1;
      while (!out_valid) begin
        @(negedge clk);
        #1;
      end
      @(posedge clk);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin
    logic [255:0] ones;
    command_code_t cmd;
    int pick;
    ones = '1;
    no_idle = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: operand extremes, every command, unreduced operands, inverse of zero.
    send(make_request(CmdAdd, 256'd0, 256'd0));
    send(make_request(CmdAdd, ones, ones));
    send(make_request(CmdAdd, OrderN - 1, 256'd1));
    send(make_request(CmdAdd, OrderN, 256'd0));
    send(make_request(CmdAdd, OrderN - 1, 256'd0));
    send(make_request(CmdMul, 256'd0, ones));
    send(make_request(CmdMul, ones, ones));
    send(make_request(CmdMul, 256'd1, 256'd1));
    send(make_request(CmdMul, OrderN - 1, OrderN - 1));
    send(make_request(CmdMul, OrderN, 256'd5));
    send(make_request(CmdReduce, 256'd0, ones));
    send(make_request(CmdReduce, OrderN - 1, 256'd0));
    send(make_request(CmdReduce, OrderN, 256'd0));
    send(make_request(CmdReduce, ones, ones));
    send(make_request(CmdInv, 256'd0, ones));
    send(make_request(CmdInv, OrderN, 256'd0));
    send(make_request(CmdInv, 256'd1, 256'd0));
    send(make_request(CmdInv, ones, ones));
    send(make_request(CmdInv, OrderN - 1, 256'd0));

    // Random: mostly add and reduce, a share of multiplies, rare inverses.
    for (int i = 0; i < NumRandom; i++) begin
      no_idle = (i >= 700 && i < 900);
      pick = $urandom_range(0, 599);
      if (pick < 2) cmd = CmdInv;
      else if (pick < 130) cmd = CmdMul;
      else if (pick < 370) cmd = CmdReduce;
      else cmd = CmdAdd;
      send(make_request(cmd, random_operand(), random_operand()));
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain until every expected result has been checked, then give the verdict.
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/p256a_pkg.sv
src/p256a_datapath.sv
src/p256a_controller.sv
src/p256_order_modular_alu_unit.sv
tb/sv/p256_alu_checker.sv
tb/sv/tb_top.sv
